@@ hw/rtl/bdbl_pkg.sv @@
// ----------------------------------------------------------------------------
// bdbl_pkg
// Shared types, constants and helpers for the dual binary rebuild line unit.
// ----------------------------------------------------------------------------
package bdbl_pkg;

   // word geometry
   localparam int WORD_BYTES = 8;
   localparam int WORD_BITS  = 8 * WORD_BYTES;
   localparam int DATA_W     = 64;
   localparam int VOL_W      = 48;
   localparam int CNT_W      = $clog2(WORD_BITS + 1);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MODE_W     = 3;
   localparam logic [CSR_ADDR_W-3:0] REG_MODE = 1'b0;

   // mode codes (6 and 7 act as plain)
   localparam logic [MODE_W-1:0] MODE_PLAIN   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_EDGE    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LEFT    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LEFT_H  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RIGHT   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RIGHT_H = 3'd5;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   typedef struct packed {
      logic [DATA_W-1:0] germ_word;
      logic [DATA_W-1:0] neighbour_word;
      logic [DATA_W-1:0] mask_word;
      logic              last_of_line;
      logic              clear_volume;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result_word;
      logic [VOL_W-1:0]  volume_total;
   } rsp_type;

   typedef struct packed {
      word_type word;
      logic     clear;
   } queue_entry_type;

   // queue status seen by the front
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   function automatic word_type bit_reverse(input word_type v);
      word_type r;
      for (int i = 0; i < WORD_BITS; i++) begin
         r[i] = v[WORD_BITS-1-i];
      end
      return r;
   endfunction

   // popcount, byte by byte then summed over the bytes
   function automatic cnt_type popcount(input word_type v);
      logic [3:0] byte_cnt;
      cnt_type    total;
      total = '0;
      for (int b = 0; b < WORD_BYTES; b++) begin
         byte_cnt = '0;
         for (int k = 0; k < 8; k++) begin
            byte_cnt = byte_cnt + 4'(v[8*b+k]);
         end
         total = total + CNT_W'(byte_cnt);
      end
      return total;
   endfunction

endpackage

@@ hw/rtl/bdbl_front.sv @@
// ----------------------------------------------------------------------------
// bdbl_front
// Takes requests, holds the line-edge carry and builds the rebuilt word.
// ----------------------------------------------------------------------------
module bdbl_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [bdbl_pkg::MODE_W-1:0] mode,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bdbl_pkg::req_type          req_data,
   input  bdbl_pkg::queue_status_type q_status,
   output logic                       q_push,
   output bdbl_pkg::queue_entry_type  q_data
);

   bdbl_pkg::word_type carry_ff;
   bdbl_pkg::word_type carry_in;

   bdbl_pkg::word_type germ, nb, msk;
   bdbl_pkg::word_type shl_nb, shr_nb;
   bdbl_pkg::word_type a_left, a_right;
   bdbl_pkg::word_type x_op, y_op, chain, horiz;
   logic               cin, go_left;
   logic [bdbl_pkg::WORD_BITS:0] sum, carries;
   bdbl_pkg::word_type result;
   logic               accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      germ = req_data.germ_word[bdbl_pkg::WORD_BITS-1:0];
      nb   = req_data.neighbour_word[bdbl_pkg::WORD_BITS-1:0];
      msk  = req_data.mask_word[bdbl_pkg::WORD_BITS-1:0];

      shl_nb = {carry_ff[0], nb[bdbl_pkg::WORD_BITS-1:1]};
      shr_nb = {nb[bdbl_pkg::WORD_BITS-2:0], carry_ff[bdbl_pkg::WORD_BITS-1]};

      // horizontal fill: r[i] = m[i] | (g[i] & g[next] & r[next]), a carry chain
      a_left  = germ & {carry_ff[0], germ[bdbl_pkg::WORD_BITS-1:1]};
      a_right = germ & {germ[bdbl_pkg::WORD_BITS-2:0], carry_ff[bdbl_pkg::WORD_BITS-1]};
      go_left = (mode == bdbl_pkg::MODE_LEFT_H);
      x_op    = go_left ? bdbl_pkg::bit_reverse(msk | a_left) : (msk | a_right);
      y_op    = go_left ? bdbl_pkg::bit_reverse(msk) : msk;
      cin     = go_left ? carry_ff[0] : carry_ff[bdbl_pkg::WORD_BITS-1];
      sum     = {1'b0, x_op} + {1'b0, y_op} + (bdbl_pkg::WORD_BITS+1)'(cin);
      carries = sum ^ {1'b0, x_op} ^ {1'b0, y_op};
      chain   = carries[bdbl_pkg::WORD_BITS:1];
      horiz   = go_left ? bdbl_pkg::bit_reverse(chain) : chain;

      carry_in = carry_ff;
      unique case (mode)
         bdbl_pkg::MODE_EDGE: begin
            result = germ | msk;
         end
         bdbl_pkg::MODE_LEFT: begin
            result   = (germ & shl_nb) | msk;
            carry_in = nb;
         end
         bdbl_pkg::MODE_RIGHT: begin
            result   = (germ & shr_nb) | msk;
            carry_in = nb;
         end
         bdbl_pkg::MODE_LEFT_H, bdbl_pkg::MODE_RIGHT_H: begin
            result   = horiz;
            carry_in = horiz;
         end
         default: begin
            result = (germ & nb) | msk;
         end
      endcase
      if (req_data.last_of_line) begin
         carry_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '1;
      end else if (accept) begin
         carry_ff <= carry_in;
      end
   end

   assign q_push       = accept;
   assign q_data.word  = result;
   assign q_data.clear = req_data.clear_volume;

`ifndef ASSERT_OFF
   a_edge_refill: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_of_line |=> carry_ff == '1)
      else $error("carry not refilled after end of line");
`endif

endmodule

@@ hw/rtl/bdbl_queue.sv @@
// ----------------------------------------------------------------------------
// bdbl_queue
// Short FIFO decoupling the word builder from the volume counter.
// ----------------------------------------------------------------------------
module bdbl_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bdbl_pkg::queue_entry_type  push_data,
   input  logic                       pop,
   output bdbl_pkg::queue_entry_type  head_data,
   output bdbl_pkg::queue_status_type status
);

   bdbl_pkg::queue_entry_type entry_ff [bdbl_pkg::QUEUE_DEPTH];
   logic [bdbl_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bdbl_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bdbl_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign status.full  = (count_ff == bdbl_pkg::QCNT_W'(bdbl_pkg::QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign head_data    = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bdbl_pkg::QCNT_W'(bdbl_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

`ifndef ASSERT_OFF
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");
`endif

endmodule

@@ hw/rtl/bdbl_back.sv @@
// ----------------------------------------------------------------------------
// bdbl_back
// Counts set pixels, keeps the saturating volume and holds the response.
// ----------------------------------------------------------------------------
module bdbl_back (
   input  logic                       clock,
   input  logic                       reset,
   input  bdbl_pkg::queue_entry_type  head_data,
   input  bdbl_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bdbl_pkg::rsp_type          rsp_data
);

   // popcount stage
   logic                    cnt_valid_ff;
   bdbl_pkg::word_type      cnt_word_ff;
   bdbl_pkg::cnt_type       cnt_ff;
   logic                    cnt_clear_ff;

   // response stage
   logic                    out_valid_ff, out_valid_in;
   bdbl_pkg::rsp_type       out_ff;
   logic [bdbl_pkg::VOL_W-1:0] vol_ff, vol_in, vol_base;
   logic [bdbl_pkg::VOL_W:0]   vol_sum;

   logic out_free, cnt_move, cnt_free;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign cnt_move = cnt_valid_ff && out_free;
   assign cnt_free = !cnt_valid_ff || cnt_move;
   assign pop      = q_status.valid && cnt_free;

   // saturating accumulate
   always_comb begin
      vol_base = cnt_clear_ff ? '0 : vol_ff;
      vol_sum  = {1'b0, vol_base} + (bdbl_pkg::VOL_W+1)'(cnt_ff);
      vol_in   = vol_sum[bdbl_pkg::VOL_W] ? '1 : vol_sum[bdbl_pkg::VOL_W-1:0];
      out_valid_in = cnt_move || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         vol_ff       <= '0;
      end else begin
         if (cnt_free) begin
            cnt_valid_ff <= q_status.valid;
         end
         out_valid_ff <= out_valid_in;
         if (cnt_move) begin
            vol_ff <= vol_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cnt_word_ff  <= head_data.word;
         cnt_ff       <= bdbl_pkg::popcount(head_data.word);
         cnt_clear_ff <= head_data.clear;
      end
      if (cnt_move) begin
         out_ff.result_word  <= bdbl_pkg::DATA_W'(cnt_word_ff);
         out_ff.volume_total <= vol_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef ASSERT_OFF
   a_volume_grows: assert property (@(posedge clock) disable iff (reset)
      cnt_move && !cnt_clear_ff |=> vol_ff >= $past(vol_ff))
      else $error("volume fell without a clear");
`endif

endmodule

@@ hw/rtl/binary_dual_build_line_word.sv @@
// Path: queue entry, then the popcount register, then the response register.
// Throughput: one request per cycle unless a full queue or a response stall holds it,
// set by the front's carry loop (horizontal fill is one carry chain) and volume sum.
// Reset (synchronous, active high): mode plain, carry all ones, volume zero,
// queue and pipeline empty; the configuration port is usable at once.
// ----------------------------------------------------------------------------
// binary_dual_build_line_word
// Dual binary geodesic rebuild of one packed pixel word, with running volume.
// ----------------------------------------------------------------------------
module binary_dual_build_line_word (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bdbl_pkg::req_type                   req_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bdbl_pkg::rsp_type                   rsp_data,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bdbl_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bdbl_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bdbl_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   // ------------------------------------------------------------------
   // Configuration: one register, the mode, at byte address 0.
   // Only the low three bits are kept; codes 6 and 7 behave as plain.
   // ------------------------------------------------------------------
   logic [bdbl_pkg::MODE_W-1:0] mode_ff;
   logic                        csr_write;
   logic                        hit_mode;

   assign pready    = 1'b1;
   assign hit_mode  = (paddr[bdbl_pkg::CSR_ADDR_W-1:2] == bdbl_pkg::REG_MODE);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bdbl_pkg::MODE_PLAIN;
      end else if (csr_write && hit_mode) begin
         mode_ff <= pwdata[bdbl_pkg::MODE_W-1:0];
      end
   end

   assign prdata = hit_mode ? bdbl_pkg::CSR_DATA_W'(mode_ff) : '0;

   // ------------------------------------------------------------------
   // Front: takes the request, applies the mode against the edge carry
   // and pushes the rebuilt word with its clear flag into the queue.
   // It stalls the request side only when the queue is full.
   // ------------------------------------------------------------------
   bdbl_pkg::queue_status_type q_status;
   bdbl_pkg::queue_entry_type  q_push_data;
   bdbl_pkg::queue_entry_type  q_head;
   logic                       q_push;
   logic                       q_pop;

   bdbl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // ------------------------------------------------------------------
   // Queue: four entries, lets the back end stall on the response side
   // without holding up the front until it fills.
   // ------------------------------------------------------------------
   bdbl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head),
      .status    (q_status)
   );

   // ------------------------------------------------------------------
   // Back: popcount stage, then the saturating volume and the response
   // register. Both stages advance whenever the stage after them frees.
   // ------------------------------------------------------------------
   bdbl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (q_head),
      .q_status  (q_status),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
